/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_NEVER(name, prop, msg)
`endif
`endif

/* design/qwsa_pkg.sv */
// Shared types, constants and the sine sample generator for the sine/arcsine table.
package qwsa_pkg;

    localparam int INDEX_BITS_DEFAULT = 10;
    localparam int OPERAND_W = 32;
    localparam int RESULT_W = 18;
    localparam int SAMPLE_W = 17;
    localparam int PHASE_FRAC = 48;
    localparam int ANGLE_FRAC = 16;
    localparam int TAYLOR_FRAC = 30;
    localparam int TAYLOR_TERMS = 7;

    localparam logic [SAMPLE_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic {
        OP_SINE = 1'b0,
        OP_ASIN = 1'b1
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic neg;
    } ctrl_t;

    // Restoring long division, evaluated only while the table is built.
    function automatic logic [63:0] div_u64(input logic [63:0] num,
                                            input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry i of the quarter-wave table, before the monotonic fix-up.
    function automatic logic [SAMPLE_W-1:0] sine_sample(input int unsigned i,
                                                        input int unsigned index_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] div;
        logic [63:0] r;
        logic signed [63:0] sum;
        int unsigned k;
        x = (64'(i) * HALF_PI_Q30) >> index_bits;
        x2 = (x * x) >> TAYLOR_FRAC;
        term = x;
        sum = signed'(x);
        for (k = 1; k <= TAYLOR_TERMS; k++)
        begin
            div = 64'((2 * k) * (2 * k + 1));
            term = div_u64((term * x2) >> TAYLOR_FRAC, div);
            if ((k & 1) != 0)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        r = (64'(sum) + (64'd1 << (TAYLOR_FRAC - ANGLE_FRAC - 1))) >> (TAYLOR_FRAC - ANGLE_FRAC);
        if (r > 64'(ONE_Q16))
        begin
            r = 64'(ONE_Q16);
        end
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

/* design/quarter_wave_sine_arcsine_table.sv */
// Top level of the pipelined quarter-wave sine and arcsine lookup block.
// Takes one item per cycle unless req_stall is raised; the pipeline depth is set by
// the arcsine search, which walks INDEX_BITS levels, each with its own registered
// ROM read, behind three front stages (magnitude, 32x32 phase multiply, fold and
// first probe read) and two back stages (last compare with angle multiply, signed
// output register). The ROM is a fixed table of 2^INDEX_BITS + 1 quarter-wave
// samples in Q16, so no fill or clear pass follows reset. Stages advance
// independently, so bubbles are squeezed out and new items are taken while a
// finished result waits at the output.
`include "assert_macros.svh"

module quarter_wave_sine_arcsine_table
    import qwsa_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        op,
    input  logic signed [OPERAND_W-1:0] operand,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic signed [RESULT_W-1:0]  result
);

    localparam logic signed [RESULT_W-1:0] RESULT_MAX = 18'sd102944;

    ctrl_t ctrl_s [0:INDEX_BITS];
    logic [SAMPLE_W-1:0] amag_s [0:INDEX_BITS];
    logic [INDEX_BITS:0] pos_s [0:INDEX_BITS];
    logic [SAMPLE_W-1:0] data_s [0:INDEX_BITS];
    logic adv_s [1:INDEX_BITS+1];
    logic front_adv;
    logic result_bad;

    assign req_stall = !front_adv;

    qwsa_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_op      (op),
        .in_operand (operand),
        .adv_out    (front_adv),
        .adv_in     (adv_s[1]),
        .out_ctrl   (ctrl_s[0]),
        .out_amag   (amag_s[0]),
        .out_pos    (pos_s[0]),
        .out_data   (data_s[0])
    );

    for (genvar l = 1; l <= INDEX_BITS; l++)
    begin : g_level
        qwsa_level #(
            .INDEX_BITS (INDEX_BITS),
            .LEVEL      (l)
        ) u_level (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv_in   (adv_s[l+1]),
            .adv_out  (adv_s[l]),
            .in_ctrl  (ctrl_s[l-1]),
            .in_amag  (amag_s[l-1]),
            .in_pos   (pos_s[l-1]),
            .in_data  (data_s[l-1]),
            .out_ctrl (ctrl_s[l]),
            .out_amag (amag_s[l]),
            .out_pos  (pos_s[l]),
            .out_data (data_s[l])
        );
    end

    qwsa_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   (ctrl_s[INDEX_BITS]),
        .in_amag   (amag_s[INDEX_BITS]),
        .in_pos    (pos_s[INDEX_BITS]),
        .in_data   (data_s[INDEX_BITS]),
        .adv_out   (adv_s[INDEX_BITS+1]),
        .out_stall (rsp_stall),
        .out_valid (rsp_valid),
        .result    (result)
    );

    assign result_bad = (result > RESULT_MAX) || (result < -RESULT_MAX);

    // An empty or draining output register lets every stage advance.
    `ASSERT_CLK(a_input_free, (!rsp_valid || !rsp_stall) |-> !req_stall, "input stalled")
    `ASSERT_NEVER(a_result_range, rsp_valid && result_bad, "result out of range")

endmodule

/* design/qwsa_rom.sv */
// Quarter-wave sine ROM with a registered read port.
module qwsa_rom
    import qwsa_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [INDEX_BITS:0] addr,
    output logic [SAMPLE_W-1:0] q
);

    localparam int N = 1 << INDEX_BITS;

    typedef logic [SAMPLE_W-1:0] rom_t [0:N];

    function automatic rom_t build_rom();
        rom_t t;
        logic [SAMPLE_W-1:0] prev;
        logic [SAMPLE_W-1:0] v;
        int i;
        prev = '0;
        for (i = 0; i < N; i++)
        begin
            v = sine_sample(i, INDEX_BITS);
            if (v < prev)
            begin
                v = prev;
            end
            t[i] = v;
            prev = v;
        end
        t[N] = ONE_Q16;
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [SAMPLE_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= ROM[addr];
        end
    end

    assign q = q_reg;

endmodule

/* design/qwsa_front.sv */
// Front stages: magnitude, phase scaling, clamp, quarter-wave fold and first table read.
module qwsa_front
    import qwsa_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_op,
    input  logic signed [OPERAND_W-1:0] in_operand,
    output logic                        adv_out,
    input  logic                        adv_in,
    output ctrl_t                       out_ctrl,
    output logic [SAMPLE_W-1:0]         out_amag,
    output logic [INDEX_BITS:0]         out_pos,
    output logic [SAMPLE_W-1:0]         out_data
);

    localparam logic [INDEX_BITS:0] FIRST_PROBE =
        (INDEX_BITS + 1)'((1 << (INDEX_BITS - 1)) - 1);

    ctrl_t ctrl1_reg, ctrl1_next;
    ctrl_t ctrl2_reg;
    ctrl_t ctrl3_reg, ctrl3_next;
    logic [OPERAND_W-1:0] mag1_reg, mag1_next;
    logic [INDEX_BITS+1:0] idx2_reg, idx2_next;
    logic [SAMPLE_W-1:0] amag2_reg, amag2_next;
    logic [SAMPLE_W-1:0] amag3_reg;
    logic [OPERAND_W-1:0] raw;
    logic [63:0] prod;
    logic [INDEX_BITS:0] half;
    logic [INDEX_BITS:0] sine_addr;
    logic [INDEX_BITS:0] rom_addr;
    logic en1, en2, en3;

    assign en3 = !ctrl3_reg.valid || adv_in;
    assign en2 = !ctrl2_reg.valid || en3;
    assign en1 = !ctrl1_reg.valid || en2;
    assign adv_out = en1;

    always_comb
    begin
        raw = in_operand;
        mag1_next = raw[OPERAND_W-1] ? (~raw + OPERAND_W'(1)) : raw;
        ctrl1_next.valid = in_valid;
        ctrl1_next.op = op_t'(in_op);
        ctrl1_next.neg = raw[OPERAND_W-1];
    end

    always_comb
    begin
        prod = 64'(mag1_reg) * 64'(TWO_OVER_PI_Q32);
        idx2_next = prod[PHASE_FRAC+1:PHASE_FRAC-INDEX_BITS];
        amag2_next = (mag1_reg > OPERAND_W'(ONE_Q16)) ? ONE_Q16 : mag1_reg[SAMPLE_W-1:0];
    end

    // The second half-wave flips the sign; the second quarter mirrors the index.
    always_comb
    begin
        half = idx2_reg[INDEX_BITS:0];
        sine_addr = half[INDEX_BITS] ? (~half + (INDEX_BITS + 1)'(1)) : half;
        rom_addr = (ctrl2_reg.op == OP_ASIN) ? FIRST_PROBE : sine_addr;
        ctrl3_next = ctrl2_reg;
        if (ctrl2_reg.op == OP_SINE)
        begin
            ctrl3_next.neg = ctrl2_reg.neg ^ idx2_reg[INDEX_BITS+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end
        else
        begin
            if (en1)
            begin
                ctrl1_reg <= ctrl1_next;
            end
            if (en2)
            begin
                ctrl2_reg <= ctrl1_reg;
            end
            if (en3)
            begin
                ctrl3_reg <= ctrl3_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mag1_reg <= mag1_next;
        end
        if (en2)
        begin
            idx2_reg <= idx2_next;
            amag2_reg <= amag2_next;
        end
        if (en3)
        begin
            amag3_reg <= amag2_reg;
        end
    end

    qwsa_rom #(
        .INDEX_BITS (INDEX_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (en3),
        .addr (rom_addr),
        .q    (out_data)
    );

    assign out_ctrl = ctrl3_reg;
    assign out_amag = amag3_reg;
    assign out_pos = '0;

endmodule

/* design/qwsa_level.sv */
// One level of the arcsine search: compare, step the position, read the next probe.
module qwsa_level
    import qwsa_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
    parameter int LEVEL = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv_in,
    output logic                adv_out,
    input  ctrl_t               in_ctrl,
    input  logic [SAMPLE_W-1:0] in_amag,
    input  logic [INDEX_BITS:0] in_pos,
    input  logic [SAMPLE_W-1:0] in_data,
    output ctrl_t               out_ctrl,
    output logic [SAMPLE_W-1:0] out_amag,
    output logic [INDEX_BITS:0] out_pos,
    output logic [SAMPLE_W-1:0] out_data
);

    localparam int CUR_SHIFT = (LEVEL < INDEX_BITS) ? (INDEX_BITS - 1 - LEVEL) : 0;
    localparam logic [INDEX_BITS:0] STEP_PREV =
        (INDEX_BITS + 1)'(1) << (INDEX_BITS - LEVEL);
    localparam logic [INDEX_BITS:0] PROBE_OFS =
        ((INDEX_BITS + 1)'(1) << CUR_SHIFT) - (INDEX_BITS + 1)'(1);

    ctrl_t ctrl_reg;
    logic [SAMPLE_W-1:0] amag_reg;
    logic [INDEX_BITS:0] pos_reg, pos_next;
    logic [SAMPLE_W-1:0] keep_reg;
    logic [INDEX_BITS:0] rom_addr;
    logic [SAMPLE_W-1:0] rom_q;
    logic hit;
    logic en;

    assign en = !ctrl_reg.valid || adv_in;
    assign adv_out = en;

    always_comb
    begin
        hit = in_data < in_amag;
        pos_next = in_pos + (hit ? STEP_PREV : '0);
        rom_addr = pos_next + PROBE_OFS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            amag_reg <= in_amag;
            pos_reg <= pos_next;
            keep_reg <= in_data;
        end
    end

    qwsa_rom #(
        .INDEX_BITS (INDEX_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (en),
        .addr (rom_addr),
        .q    (rom_q)
    );

    assign out_ctrl = ctrl_reg;
    assign out_amag = amag_reg;
    assign out_pos = pos_reg;
    assign out_data = (ctrl_reg.op == OP_ASIN) ? rom_q : keep_reg;

endmodule

/* design/qwsa_back.sv */
// Back stages: last search step, angle scaling and signed output register.
module qwsa_back
    import qwsa_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_t                      in_ctrl,
    input  logic [SAMPLE_W-1:0]        in_amag,
    input  logic [INDEX_BITS:0]        in_pos,
    input  logic [SAMPLE_W-1:0]        in_data,
    output logic                       adv_out,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic signed [RESULT_W-1:0] result
);

    localparam int PROD_W = INDEX_BITS + 1 + $bits(HALF_PI_Q32);
    localparam logic [PROD_W-1:0] ANG_ROUND =
        PROD_W'(1) << (ANGLE_FRAC - 1 + INDEX_BITS);

    ctrl_t ctrlm_reg;
    logic [SAMPLE_W-1:0] magm_reg, magm_next;
    logic valid_reg;
    logic [RESULT_W-1:0] result_reg, result_next;
    logic [INDEX_BITS:0] pos_final;
    logic [PROD_W-1:0] ang_prod;
    logic hit;
    logic enm, eno;

    assign eno = !valid_reg || !out_stall;
    assign enm = !ctrlm_reg.valid || eno;
    assign adv_out = enm;

    always_comb
    begin
        hit = in_data < in_amag;
        pos_final = in_pos + (INDEX_BITS + 1)'(hit);
        ang_prod = PROD_W'(pos_final) * PROD_W'(HALF_PI_Q32) + ANG_ROUND;
        magm_next = (in_ctrl.op == OP_ASIN) ?
            ang_prod[ANGLE_FRAC+INDEX_BITS +: SAMPLE_W] : in_data;
    end

    always_comb
    begin
        result_next = {1'b0, magm_reg};
        if (ctrlm_reg.neg)
        begin
            result_next = ~{1'b0, magm_reg} + RESULT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrlm_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (enm)
            begin
                ctrlm_reg <= in_ctrl;
            end
            if (eno)
            begin
                valid_reg <= ctrlm_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enm)
        begin
            magm_reg <= magm_next;
        end
        if (eno)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result = signed'(result_reg);

endmodule

/* tb/sv/tb_quarter_wave_sine_arcsine_table.sv */
// Self-checking testbench for the quarter-wave sine and arcsine lookup block.
`timescale 1ns / 1ps

module tb_quarter_wave_sine_arcsine_table;
    import qwsa_pkg::*;

    localparam int IDX_BITS = INDEX_BITS_DEFAULT;
    localparam int unsigned ROM_N = 1 << IDX_BITS;
    localparam int RANDOM_ITEMS = 750;
    localparam int BURST_ITEMS = 60;
    localparam int SQUEEZE_CYCLES = 100;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_DIRECTED = 22;

    typedef struct packed {
        op_t                kind;
        logic signed [31:0] value;
        logic               typed;
        logic signed [17:0] want;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{OP_SINE, 32'sd0,            1'b1, 18'sd0},
        '{OP_ASIN, 32'sd0,            1'b1, 18'sd0},
        '{OP_SINE, 32'sd102944,       1'b1, 18'sd65536},
        '{OP_SINE, -32'sd102944,      1'b1, -18'sd65536},
        '{OP_SINE, 32'sd1,            1'b0, 18'sd0},
        '{OP_SINE, -32'sd1,           1'b0, 18'sd0},
        '{OP_SINE, 32'sd51472,        1'b0, 18'sd0},
        '{OP_SINE, 32'sd205888,       1'b0, 18'sd0},
        '{OP_SINE, 32'sd308832,       1'b0, 18'sd0},
        '{OP_SINE, 32'sd411775,       1'b0, 18'sd0},
        '{OP_SINE, 32'sh7fff_ffff,    1'b0, 18'sd0},
        '{OP_SINE, 32'sh8000_0000,    1'b0, 18'sd0},
        '{OP_SINE, 32'sh4000_0000,    1'b0, 18'sd0},
        '{OP_ASIN, 32'sd65536,        1'b0, 18'sd0},
        '{OP_ASIN, -32'sd65536,       1'b0, 18'sd0},
        '{OP_ASIN, 32'sd65537,        1'b0, 18'sd0},
        '{OP_ASIN, 32'sh7fff_ffff,    1'b0, 18'sd0},
        '{OP_ASIN, 32'sh8000_0000,    1'b0, 18'sd0},
        '{OP_ASIN, 32'sd1,            1'b0, 18'sd0},
        '{OP_ASIN, -32'sd1,           1'b0, 18'sd0},
        '{OP_ASIN, 32'sd46341,        1'b0, 18'sd0},
        '{OP_ASIN, -32'sd32768,       1'b0, 18'sd0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic                       op;
    logic signed [OPERAND_W-1:0] operand;
    logic                       rsp_valid;
    logic                       rsp_stall;
    logic signed [RESULT_W-1:0] result;

    logic [SAMPLE_W-1:0]        quarter_rom [ROM_N + 1];
    logic signed [RESULT_W-1:0] expected_results [$];
    int                         errors;
    int                         cycles;
    int                         sine_count;
    int                         asin_count;
    int                         checked_count;
    bit                         squeeze_req;
    bit                         squeeze_done;

    quarter_wave_sine_arcsine_table #(
        .INDEX_BITS(IDX_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .op(op),
        .operand(operand),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .result(result)
    );

    always #4 clk = ~clk;

    function automatic logic [SAMPLE_W-1:0] taylor_sample(int unsigned idx);
        logic [63:0] angle;
        logic [63:0] angle_sq;
        logic [63:0] term;
        logic [63:0] rounded;
        logic signed [63:0] acc;
        angle = (64'(idx) * HALF_PI_Q30) >> IDX_BITS;
        angle_sq = (angle * angle) >> 30;
        term = angle;
        acc = signed'(angle);
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * angle_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            acc = (k % 2 == 1) ? acc - signed'(term) : acc + signed'(term);
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        rounded = (64'(acc) + 64'd8192) >> 14;
        if (rounded > 64'd65536)
        begin
            rounded = 64'd65536;
        end
        return rounded[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [RESULT_W-1:0] trig_result(op_t kind,
                                                               logic signed [31:0] value);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] phase;
        logic [63:0] amount;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        neg = value[31];
        mag = neg ? (~value + 32'd1) : value;
        if (kind == OP_SINE)
        begin
            phase = (64'(mag) * 64'(TWO_OVER_PI_Q32)) >> (PHASE_FRAC - IDX_BITS);
            phase = phase & 64'(4 * ROM_N - 1);
            if (phase[IDX_BITS + 1])
            begin
                neg = ~neg;
            end
            phase = phase & 64'(2 * ROM_N - 1);
            if (phase >= 64'(ROM_N))
            begin
                phase = 64'(2 * ROM_N) - phase;
            end
            amount = 64'(quarter_rom[phase]);
        end
        else
        begin
            if (mag > 32'd65536)
            begin
                mag = 32'd65536;
            end
            lo = 0;
            hi = ROM_N + 1;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (32'(quarter_rom[mid]) < mag)
                begin
                    lo = mid + 1;
                end
                else
                begin
                    hi = mid;
                end
            end
            amount = (64'(lo) * 64'(HALF_PI_Q32) + (64'd1 << (15 + IDX_BITS)))
                     >> (16 + IDX_BITS);
        end
        return neg ? RESULT_W'(64'd0 - amount) : RESULT_W'(amount);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        else if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic offer(op_t kind, logic signed [31:0] value, int gap, logic typed,
                         logic signed [17:0] want);
        req_valid <= 1'b1;
        op <= kind;
        operand <= value;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        expected_results.insert(expected_results.size(),
                                typed ? want : trig_result(kind, value));
        if (kind == OP_SINE)
        begin
            sine_count++;
        end
        else
        begin
            asin_count++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result: unexpected transfer, actual %0d", result);
                errors++;
            end
            else
            begin
                if (result !== expected_results[0])
                begin
                    $error("result: expected %0d, actual %0d", expected_results[0], result);
                    errors++;
                end
                void'(expected_results.pop_front());
                checked_count++;
            end
        end
    end

    initial
    begin
        int quiet;
        int hold;
        rsp_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                rsp_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            quiet = $urandom_range(1, 40);
            hold = pick_gap();
            rsp_stall <= 1'b0;
            repeat (quiet) @(posedge clk);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    initial
    begin
        op_t                kind;
        logic signed [31:0] value;
        int                 roll;
        int                 gap;
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        op = 1'b0;
        operand = '0;
        errors = 0;
        cycles = 0;
        sine_count = 0;
        asin_count = 0;
        checked_count = 0;
        squeeze_req = 1'b0;
        squeeze_done = 1'b0;
        for (int unsigned i = 0; i < ROM_N; i++)
        begin
            quarter_rom[i] = taylor_sample(i);
            if (i > 0 && quarter_rom[i] < quarter_rom[i - 1])
            begin
                quarter_rom[i] = quarter_rom[i - 1];
            end
        end
        quarter_rom[ROM_N] = ONE_Q16;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            offer(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value, pick_gap(),
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        squeeze_req = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = op_t'($urandom_range(0, 1));
            roll = $urandom_range(0, 9);
            if (kind == OP_SINE)
            begin
                if (roll < 6)
                begin
                    value = $signed($urandom_range(0, 900000)) - 32'sd450000;
                end
                else if (roll < 8)
                begin
                    value = $signed($urandom_range(0, 8)) * 32'sd102944
                            + $signed($urandom_range(0, 64)) - 32'sd32;
                    value = $urandom_range(0, 1) ? -value : value;
                end
                else
                begin
                    value = $urandom;
                end
            end
            else
            begin
                if (roll < 6)
                begin
                    value = $signed($urandom_range(0, 140000)) - 32'sd70000;
                end
                else if (roll < 8)
                begin
                    value = 32'sd65536 - $signed($urandom_range(0, 400));
                    value = $urandom_range(0, 1) ? -value : value;
                end
                else
                begin
                    value = $urandom;
                end
            end
            gap = (i < BURST_ITEMS || !squeeze_done) ? 0 : pick_gap();
            offer(kind, value, gap, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sine and %0d arcsine transfers, %0d results checked.",
                 sine_count, asin_count, checked_count);
        $display("Operands spanned zero, full-scale angles, wrap-around and clamped values.");
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/qwsa_pkg.sv
design/qwsa_rom.sv
design/qwsa_front.sv
design/qwsa_level.sv
design/qwsa_back.sv
design/quarter_wave_sine_arcsine_table.sv
tb/sv/tb_quarter_wave_sine_arcsine_table.sv
